// ----- rtl/mppt_pkg.sv -----
`default_nettype none

package mppt_pkg;

    localparam int MAX_DEVICES = 8;
    localparam int SLOT_W      = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;

    localparam int ID_W     = 32;
    localparam int DELTA_W  = 16;
    localparam int POS_W    = 12;
    localparam int QIDX_W   = 6;
    localparam int COUNT_W  = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W    = 12;

    localparam logic [POS_W-1:0] X_LIMIT_RST = 12'd1280;
    localparam logic [POS_W-1:0] Y_LIMIT_RST = 12'd720;

    typedef enum logic
    {
        CMD_MOTION = 1'b0,
        CMD_QUERY  = 1'b1
    } command_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_X_LIMIT = 1'b0,
        REG_Y_LIMIT = 1'b1
    } cfg_reg_t;

    // Controller to datapath
    typedef struct packed
    {
        logic capture;
        logic lookup;
        logic commit;
    } dp_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/mppt_if.sv -----
`default_nettype none

interface mppt_in_if;
    logic                                       valid;
    logic                                       ready;
    logic                                       command;
    logic [mppt_pkg::ID_W-1:0]                  device_id;
    logic signed [mppt_pkg::DELTA_W-1:0]        delta_x;
    logic signed [mppt_pkg::DELTA_W-1:0]        delta_y;
    logic [mppt_pkg::QIDX_W-1:0]                query_index;
    logic                                       query_axis;

    modport source (output valid, command, device_id, delta_x, delta_y,
                    query_index, query_axis, input ready);
    modport sink   (input valid, command, device_id, delta_x, delta_y,
                    query_index, query_axis, output ready);
endinterface

interface mppt_out_if;
    logic                               valid;
    logic                               ready;
    logic [mppt_pkg::POS_W-1:0]         coordinate;
    logic [mppt_pkg::POS_W-1:0]         pos_x;
    logic [mppt_pkg::POS_W-1:0]         pos_y;
    logic [mppt_pkg::COUNT_W-1:0]       device_count;
    logic                               dropped;

    modport source (output valid, coordinate, pos_x, pos_y, device_count, dropped,
                    input ready);
    modport sink   (input valid, coordinate, pos_x, pos_y, device_count, dropped,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/multi_pointer_position_table.sv -----
// Channel  Dir  Payload                                                     Handshake
// in_ch    in   command, device_id, delta_x, delta_y, query_index, query_axis  valid/ready
// out_ch   out  coordinate, pos_x, pos_y, device_count, dropped             valid/ready
// cfg      in   cfg_index (0 x_limit, 1 y_limit), cfg_data                  cfg_we
//
// Each item is handled in order: capture, id match over the 8-entry table, then
// add/clamp with write-back into the output register.
// The output register lets the next item be taken while a result waits;
// execute holds only while that register is still full.
// Reset clears the device count and loads the limits to 1280 and 720; no
// table sweep is needed since only entries below the count are read.
`default_nettype none

module multi_pointer_position_table
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    mppt_in_if.sink                                 in_ch,
    mppt_out_if.source                              out_ch,
    input  wire logic                               cfg_we,
    input  wire logic [mppt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [mppt_pkg::CFG_W-1:0]         cfg_data
);

    mppt_pkg::dp_cmd_t cmd;

    mppt_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd)
    );

    mppt_dp u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_command     (in_ch.command),
        .in_device_id   (in_ch.device_id),
        .in_delta_x     (in_ch.delta_x),
        .in_delta_y     (in_ch.delta_y),
        .in_query_index (in_ch.query_index),
        .in_query_axis  (in_ch.query_axis),
        .coordinate     (out_ch.coordinate),
        .pos_x          (out_ch.pos_x),
        .pos_y          (out_ch.pos_y),
        .device_count   (out_ch.device_count),
        .dropped        (out_ch.dropped)
    );

endmodule

`default_nettype wire

// ----- rtl/mppt_ctrl.sv -----
`default_nettype none

module mppt_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output mppt_pkg::dp_cmd_t       cmd
);

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_LOOK,
        S_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_LOOK;
                end
            end
            S_LOOK:
            begin
                cmd.lookup = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                // hold until the output register can take the beat
                if (slot_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || out_ready))
        else $error("commit while output beat still pending");

    a_look_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LOOK |=> state_reg == S_EXEC)
        else $error("lookup not followed by execute");

    a_commit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg && state_reg == S_IDLE)
        else $error("commit did not present a result");

endmodule

`default_nettype wire

// ----- rtl/mppt_dp.sv -----
`default_nettype none

module mppt_dp
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire mppt_pkg::dp_cmd_t                  cmd,
    input  wire logic                               cfg_we,
    input  wire logic [mppt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [mppt_pkg::CFG_W-1:0]         cfg_data,
    input  wire logic                               in_command,
    input  wire logic [mppt_pkg::ID_W-1:0]          in_device_id,
    input  wire logic signed [mppt_pkg::DELTA_W-1:0] in_delta_x,
    input  wire logic signed [mppt_pkg::DELTA_W-1:0] in_delta_y,
    input  wire logic [mppt_pkg::QIDX_W-1:0]        in_query_index,
    input  wire logic                               in_query_axis,
    output logic [mppt_pkg::POS_W-1:0]              coordinate,
    output logic [mppt_pkg::POS_W-1:0]              pos_x,
    output logic [mppt_pkg::POS_W-1:0]              pos_y,
    output logic [mppt_pkg::COUNT_W-1:0]            device_count,
    output logic                                    dropped
);

    localparam int SUM_W = mppt_pkg::DELTA_W + 2;

    function automatic logic [mppt_pkg::POS_W-1:0] clamp_axis
    (
        input logic [mppt_pkg::POS_W-1:0]         pos,
        input logic signed [mppt_pkg::DELTA_W-1:0] delta,
        input logic [mppt_pkg::POS_W-1:0]         limit
    );
        logic signed [SUM_W-1:0] sum;
        logic signed [SUM_W-1:0] lim_ext;
        logic [mppt_pkg::POS_W-1:0] res;
        sum     = $signed({{(SUM_W-mppt_pkg::POS_W){1'b0}}, pos})
                + $signed({{(SUM_W-mppt_pkg::DELTA_W){delta[mppt_pkg::DELTA_W-1]}}, delta});
        lim_ext = $signed({{(SUM_W-mppt_pkg::POS_W){1'b0}}, limit});
        if (sum <= 0)
            res = '0;
        else if (sum >= lim_ext)
            res = limit;
        else
            res = sum[mppt_pkg::POS_W-1:0];
        return res;
    endfunction

    // configuration
    logic [mppt_pkg::POS_W-1:0] x_limit_reg;
    logic [mppt_pkg::POS_W-1:0] y_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_limit_reg <= mppt_pkg::X_LIMIT_RST;
            y_limit_reg <= mppt_pkg::Y_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (mppt_pkg::cfg_reg_t'(cfg_index))
                mppt_pkg::REG_X_LIMIT: x_limit_reg <= cfg_data;
                mppt_pkg::REG_Y_LIMIT: y_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // captured input beat
    logic                                   cmd_reg;
    logic [mppt_pkg::ID_W-1:0]              id_reg;
    logic signed [mppt_pkg::DELTA_W-1:0]    dx_reg;
    logic signed [mppt_pkg::DELTA_W-1:0]    dy_reg;
    logic [mppt_pkg::QIDX_W-1:0]            qidx_reg;
    logic                                   qaxis_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg   <= in_command;
            id_reg    <= in_device_id;
            dx_reg    <= in_delta_x;
            dy_reg    <= in_delta_y;
            qidx_reg  <= in_query_index;
            qaxis_reg <= in_query_axis;
        end
    end

    // table
    logic [mppt_pkg::ID_W-1:0]  ids_reg [mppt_pkg::MAX_DEVICES];
    logic [mppt_pkg::POS_W-1:0] ex_reg  [mppt_pkg::MAX_DEVICES];
    logic [mppt_pkg::POS_W-1:0] ey_reg  [mppt_pkg::MAX_DEVICES];
    logic [mppt_pkg::COUNT_W-1:0] used_reg, used_next;

    // lookup stage: parallel id match
    logic [mppt_pkg::MAX_DEVICES-1:0] match;
    logic                             hit;
    logic [mppt_pkg::SLOT_W-1:0]      hit_slot;
    logic                             room;
    logic [mppt_pkg::SLOT_W-1:0]      slot_reg, slot_next;
    logic                             ok_reg, ok_next;
    logic                             new_reg, new_next;

    always_comb
    begin
        for (int i = 0; i < mppt_pkg::MAX_DEVICES; i++)
        begin
            match[i] = (mppt_pkg::COUNT_W'(i) < used_reg) && (ids_reg[i] == id_reg);
        end
        hit      = |match;
        hit_slot = '0;
        for (int i = mppt_pkg::MAX_DEVICES - 1; i >= 0; i--)
        begin
            if (match[i])
                hit_slot = mppt_pkg::SLOT_W'(i);
        end
        room = used_reg < mppt_pkg::COUNT_W'(mppt_pkg::MAX_DEVICES);

        if (mppt_pkg::command_t'(cmd_reg) == mppt_pkg::CMD_MOTION)
        begin
            slot_next = hit ? hit_slot : used_reg[mppt_pkg::SLOT_W-1:0];
            ok_next   = hit || room;
            new_next  = !hit && room;
        end
        else
        begin
            slot_next = qidx_reg[mppt_pkg::SLOT_W-1:0];
            ok_next   = {{(mppt_pkg::COUNT_W-mppt_pkg::QIDX_W){1'b0}}, qidx_reg} < used_reg;
            new_next  = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            slot_reg <= slot_next;
            ok_reg   <= ok_next;
            new_reg  <= new_next;
        end
    end

    // execute stage: read the slot; add and clamp for motion, pass the entry through for query
    logic                       is_motion;
    logic [mppt_pkg::POS_W-1:0] rd_x, rd_y;
    logic [mppt_pkg::POS_W-1:0] base_x, base_y;
    logic [mppt_pkg::POS_W-1:0] new_x, new_y;
    logic [mppt_pkg::POS_W-1:0] res_x, res_y, res_coord;

    always_comb
    begin
        is_motion = (mppt_pkg::command_t'(cmd_reg) == mppt_pkg::CMD_MOTION);
        rd_x      = ex_reg[slot_reg];
        rd_y      = ey_reg[slot_reg];
        base_x    = new_reg ? '0 : rd_x;
        base_y    = new_reg ? '0 : rd_y;
        new_x     = clamp_axis(base_x, dx_reg, x_limit_reg);
        new_y     = clamp_axis(base_y, dy_reg, y_limit_reg);
        used_next = used_reg + mppt_pkg::COUNT_W'(new_reg);
        res_x     = '0;
        res_y     = '0;
        res_coord = '0;
        if (ok_reg)
        begin
            if (is_motion)
            begin
                res_x     = new_x;
                res_y     = new_y;
                res_coord = new_x;
            end
            else
            begin
                res_x     = rd_x;
                res_y     = rd_y;
                res_coord = qaxis_reg ? rd_x : rd_y;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && is_motion && ok_reg)
        begin
            ex_reg[slot_reg] <= new_x;
            ey_reg[slot_reg] <= new_y;
            if (new_reg)
                ids_reg[slot_reg] <= id_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            used_reg <= '0;
        else if (cmd.commit)
            used_reg <= used_next;
    end

    // output beat
    logic [mppt_pkg::POS_W-1:0]   coord_reg, px_reg, py_reg;
    logic [mppt_pkg::COUNT_W-1:0] count_reg;
    logic                         drop_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            coord_reg <= res_coord;
            px_reg    <= res_x;
            py_reg    <= res_y;
            count_reg <= used_next;
            drop_reg  <= is_motion && !ok_reg;
        end
    end

    assign coordinate   = coord_reg;
    assign pos_x        = px_reg;
    assign pos_y        = py_reg;
    assign device_count = count_reg;
    assign dropped      = drop_reg;

    a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= mppt_pkg::COUNT_W'(mppt_pkg::MAX_DEVICES))
        else $error("device count beyond table size");

    a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg != $past(used_reg) |-> $past(cmd.commit)
            && used_reg == $past(used_reg) + mppt_pkg::COUNT_W'(1))
        else $error("device count changed outside an allocating commit");

    a_alloc_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && new_reg |-> used_reg < mppt_pkg::COUNT_W'(mppt_pkg::MAX_DEVICES))
        else $error("allocation into a full table");

endmodule

`default_nettype wire
